// File: sv/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HEX2   = 3'd3,
    PH_HEX3   = 3'd4,
    PH_HEX4   = 3'd5,
    PH_DROP   = 3'd6
  } phase_e;

  localparam int unsigned MaxRes = 3;

  // escape characters
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChU         = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } res_t;

  typedef res_t [MaxRes-1:0] res_arr_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/json_string_unescape_utf8.sv
`default_nettype none
// JSON string-body unescaper: takes one escaped byte per transaction and returns the
// unescaped bytes, with \uXXXX turned into 1 to 3 UTF-8 bytes. Input bytes go into an
// input register, are decoded combinationally and land in a three-entry result buffer;
// while the output is ready, the buffer drains and the input is taken at one byte per
// cycle, but a \u escape that yields 2 or 3 UTF-8 bytes holds the input while the
// result buffer drains. A byte passes the input register and then the result buffer
// before its result appears. An unknown or unterminated escape gives a single result
// with tuser and tlast set, and the rest of that string is dropped up to its tlast byte.
module json_string_unescape_utf8 (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,  // [7:0] out_byte
  output logic            m_axis_tlast_o,
  output logic            m_axis_tuser_o   // [0] bad_escape
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              fire;
  logic              load_ok;
  logic [1:0]        dec_count;
  jsu_pkg::res_arr_t dec_res;
  jsu_pkg::res_t     head;

  assign fire            = in_valid_q && ((dec_count == 2'd0) || load_ok);
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .res_o   (dec_res),
    .count_o (dec_count)
  );

  jsu_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire && (dec_count != 2'd0)),
    .res_i     (dec_res),
    .count_i   (dec_count),
    .load_ok_o (load_ok),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .head_o    (head)
  );

  assign m_axis_tdata_o = head.data;
  assign m_axis_tlast_o = head.last;
  assign m_axis_tuser_o = head.bad;

`ifndef SYNTHESIS
  // an error result always closes the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("error result without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("error result with nonzero data");

  // results are only loaded while the buffer can take them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && dec_count != 2'd0 |-> load_ok)
    else $error("result buffer overrun");
`endif

endmodule
`default_nettype wire

// File: sv/jsu_decode.sv
`default_nettype none
module jsu_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output jsu_pkg::res_arr_t      res_o,
  output logic [1:0]             count_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [11:0]     acc_q, acc_d;
  logic [15:0]     cp;
  logic [3:0]      hv;

  assign hv = jsu_pkg::hex_value(byte_i);
  assign cp = {acc_q, hv};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    count_o = 2'd0;
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      res_o[i] = '0;
    end
    unique case (phase_q)
      jsu_pkg::PH_NORMAL: begin
        if (byte_i != jsu_pkg::ChBackslash) begin
          res_o[0] = '{data: byte_i, last: last_i, bad: 1'b0};
          count_o  = 2'd1;
        end else if (last_i) begin
          res_o[0] = '{data: 8'h00, last: 1'b1, bad: 1'b1};
          count_o  = 2'd1;
          acc_d    = '0;
        end else begin
          phase_d = jsu_pkg::PH_ESCAPE;
        end
      end
      jsu_pkg::PH_ESCAPE: begin
        count_o = 2'd1;
        phase_d = jsu_pkg::PH_NORMAL;
        res_o[0].last = last_i;
        unique case (byte_i)
          jsu_pkg::ChBackslash: res_o[0].data = 8'h5c;
          jsu_pkg::ChQuote:     res_o[0].data = 8'h22;
          jsu_pkg::ChT:         res_o[0].data = 8'h09;
          jsu_pkg::ChR:         res_o[0].data = 8'h0d;
          jsu_pkg::ChN:         res_o[0].data = 8'h0a;
          jsu_pkg::ChB:         res_o[0].data = 8'h08;
          jsu_pkg::ChF:         res_o[0].data = 8'h0c;
          jsu_pkg::ChU: begin
            acc_d = '0;
            if (last_i) begin
              res_o[0] = '{data: 8'h00, last: 1'b1, bad: 1'b1};
            end else begin
              count_o = 2'd0;
              phase_d = jsu_pkg::PH_HEX1;
            end
          end
          default: begin
            res_o[0] = '{data: 8'h00, last: 1'b1, bad: 1'b1};
            acc_d    = '0;
            phase_d  = last_i ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
          end
        endcase
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
        if (last_i) begin
          res_o[0] = '{data: 8'h00, last: 1'b1, bad: 1'b1};
          count_o  = 2'd1;
          acc_d    = '0;
          phase_d  = jsu_pkg::PH_NORMAL;
        end else begin
          acc_d   = {acc_q[7:0], hv};
          phase_d = jsu_pkg::phase_e'(phase_q + 3'd1);
        end
      end
      jsu_pkg::PH_HEX4: begin
        phase_d = jsu_pkg::PH_NORMAL;
        acc_d   = '0;
        if (cp[15:7] == '0) begin
          res_o[0] = '{data: cp[7:0], last: last_i, bad: 1'b0};
          count_o  = 2'd1;
        end else if (cp[15:11] == '0) begin
          res_o[0] = '{data: {3'b110, cp[10:6]}, last: 1'b0, bad: 1'b0};
          res_o[1] = '{data: {2'b10, cp[5:0]}, last: last_i, bad: 1'b0};
          count_o  = 2'd2;
        end else begin
          res_o[0] = '{data: {4'b1110, cp[15:12]}, last: 1'b0, bad: 1'b0};
          res_o[1] = '{data: {2'b10, cp[11:6]}, last: 1'b0, bad: 1'b0};
          res_o[2] = '{data: {2'b10, cp[5:0]}, last: last_i, bad: 1'b0};
          count_o  = 2'd3;
        end
      end
      default: begin
        // dropping the rest of a bad string
        phase_d = last_i ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_NORMAL;
      acc_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/jsu_outbuf.sv
`default_nettype none
module jsu_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire jsu_pkg::res_arr_t res_i,
  input  wire logic [1:0]        count_i,
  output logic                   load_ok_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output jsu_pkg::res_t          head_o
);

  jsu_pkg::res_arr_t ent_q, ent_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign valid_o   = (cnt_q != 2'd0);
  assign head_o    = ent_q[0];
  assign pop       = valid_o && ready_i;
  // new results may land once the last pending one leaves
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = res_i;
      cnt_d = count_i;
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RandomBytes = 240;
  // control characters produced by the short escapes
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlCr  = 8'h0d;
  localparam logic [7:0] CtlLf  = 8'h0a;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0c;

  typedef struct packed {
    logic [7:0]    ch;
    logic          fin;
    logic          typed;
    jsu_pkg::res_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data;
  logic       out_last;
  logic       out_bad;

  // predictor state
  jsu_pkg::phase_e esc_phase = jsu_pkg::PH_NORMAL;
  logic [11:0]     cp_acc = 12'h000;

  jsu_pkg::res_t unesc_q[$];
  stim_row_t     dir_rows[$];

  int errors = 0;
  int bytes_in = 0;
  int live_items = 0;
  int bytes_out = 0;
  int strings_sent = 0;
  int unicode_seen = 0;
  int malformed_seen = 0;
  int burst_left = 0;
  int stall_left = 0;
  int rx_mode = 0;

  json_string_unescape_utf8 u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_bad)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("json_string_unescape_utf8 verification failed");
    $finish;
  end

  function automatic jsu_pkg::res_t res_of(input logic [7:0] d, input logic l,
                                           input logic bad);
    jsu_pkg::res_t r;
    r.data = d;
    r.last = l;
    r.bad  = bad;
    return r;
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= "0" && c <= "9") v = c[3:0];
    else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) v = 4'(c[3:0] + 4'd9);
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    logic [7:0] c;
    if (v < 4'd10) c = 8'("0" + v);
    else if (upper) c = 8'("A" + v - 4'd10);
    else c = 8'("a" + v - 4'd10);
    return c;
  endfunction

  function automatic bit is_escape_char(input logic [7:0] c);
    return c == jsu_pkg::ChBackslash || c == jsu_pkg::ChQuote || c == jsu_pkg::ChT ||
           c == jsu_pkg::ChR || c == jsu_pkg::ChN || c == jsu_pkg::ChB ||
           c == jsu_pkg::ChF || c == jsu_pkg::ChU;
  endfunction

  function automatic logic [7:0] escape_char(input int k);
    logic [7:0] c;
    case (k)
      0: c = jsu_pkg::ChBackslash;
      1: c = jsu_pkg::ChQuote;
      2: c = jsu_pkg::ChT;
      3: c = jsu_pkg::ChR;
      4: c = jsu_pkg::ChN;
      5: c = jsu_pkg::ChB;
      default: c = jsu_pkg::ChF;
    endcase
    return c;
  endfunction

  // error result; the rest of the string is dropped unless this byte ends it
  function automatic jsu_pkg::res_t malformed(input logic fin);
    esc_phase = fin ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
    cp_acc = 12'h000;
    malformed_seen++;
    return res_of(8'h00, 1'b1, 1'b1);
  endfunction

  function automatic int unescape_byte(input logic [7:0] b, input logic fin,
                                       output jsu_pkg::res_arr_t r);
    logic [15:0] cp;
    logic [7:0]  m;
    int          n;
    r = '0;
    n = 0;
    case (esc_phase)
      jsu_pkg::PH_NORMAL: begin
        if (b != jsu_pkg::ChBackslash) begin
          r[0] = res_of(b, fin, 1'b0);
          n = 1;
        end else if (fin) begin
          r[0] = malformed(fin);
          n = 1;
        end else begin
          esc_phase = jsu_pkg::PH_ESCAPE;
        end
      end
      jsu_pkg::PH_ESCAPE: begin
        n = 1;
        case (b)
          jsu_pkg::ChBackslash, jsu_pkg::ChQuote: m = b;
          jsu_pkg::ChT: m = CtlTab;
          jsu_pkg::ChR: m = CtlCr;
          jsu_pkg::ChN: m = CtlLf;
          jsu_pkg::ChB: m = CtlBs;
          jsu_pkg::ChF: m = CtlFf;
          jsu_pkg::ChU: begin
            if (fin) begin
              r[0] = malformed(fin);
            end else begin
              esc_phase = jsu_pkg::PH_HEX1;
              cp_acc = 12'h000;
              n = 0;
            end
          end
          default: r[0] = malformed(fin);
        endcase
        if (esc_phase == jsu_pkg::PH_ESCAPE) begin
          r[0] = res_of(m, fin, 1'b0);
          esc_phase = jsu_pkg::PH_NORMAL;
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
        if (fin) begin
          r[0] = malformed(fin);
          n = 1;
        end else begin
          cp_acc = {cp_acc[7:0], nibble_of(b)};
          esc_phase = jsu_pkg::phase_e'(esc_phase + 3'd1);
        end
      end
      jsu_pkg::PH_HEX4: begin
        cp = {cp_acc, nibble_of(b)};
        esc_phase = jsu_pkg::PH_NORMAL;
        cp_acc = 12'h000;
        unicode_seen++;
        if (cp < 16'h0080) begin
          r[0] = res_of(cp[7:0], fin, 1'b0);
          n = 1;
        end else if (cp < 16'h0800) begin
          r[0] = res_of({3'b110, cp[10:6]}, 1'b0, 1'b0);
          r[1] = res_of({2'b10, cp[5:0]}, fin, 1'b0);
          n = 2;
        end else begin
          r[0] = res_of({4'b1110, cp[15:12]}, 1'b0, 1'b0);
          r[1] = res_of({2'b10, cp[11:6]}, 1'b0, 1'b0);
          r[2] = res_of({2'b10, cp[5:0]}, fin, 1'b0);
          n = 3;
        end
      end
      default: esc_phase = fin ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
    endcase
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input jsu_pkg::res_t want);
    jsu_pkg::res_arr_t got;
    int                n;
    int                gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_last  <= fin;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    bytes_in++;
    if (esc_phase != jsu_pkg::PH_DROP) live_items++;
    n = unescape_byte(b, fin, got);
    if (typed) unesc_q.push_back(want);
    else for (int k = 0; k < n; k++) unesc_q.push_back(got[k]);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (unesc_q.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] ch, input logic fin, input logic typed,
                         input logic [7:0] d, input logic l, input logic bad);
    stim_row_t row;
    row.ch    = ch;
    row.fin   = fin;
    row.typed = typed;
    row.want  = res_of(d, l, bad);
    dir_rows.push_back(row);
  endtask

  task automatic send_string();
    logic [7:0]  s[$];
    logic [15:0] cp;
    logic [7:0]  c;
    int          ntok;
    int          kind;
    int          cut;
    if ($urandom_range(0, 11) == 0) begin
      // noise: random bytes, backslash often
      repeat ($urandom_range(1, 6)) begin
        c = ($urandom_range(0, 3) == 0) ? jsu_pkg::ChBackslash
                                        : 8'($urandom_range(0, 255));
        s.push_back(c);
      end
    end else begin
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          s.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 72) begin
          s.push_back(jsu_pkg::ChBackslash);
          s.push_back(escape_char($urandom_range(0, 6)));
        end else if (kind < 93) begin
          case ($urandom_range(0, 4))
            0: cp = 16'($urandom_range(16'h0000, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
            3: cp = 16'($urandom_range(16'hd800, 16'hdfff));
            default: begin
              case ($urandom_range(0, 5))
                0: cp = 16'h0000;
                1: cp = 16'h007f;
                2: cp = 16'h0080;
                3: cp = 16'h07ff;
                4: cp = 16'h0800;
                default: cp = 16'hffff;
              endcase
            end
          endcase
          s.push_back(jsu_pkg::ChBackslash);
          s.push_back(jsu_pkg::ChU);
          for (int k = 3; k >= 0; k--) begin
            c = hex_char(cp[4*k +: 4], 1'($urandom_range(0, 1)));
            // now and then a character that is not a hex digit
            if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
            s.push_back(c);
          end
        end else if (kind < 97) begin
          do c = 8'($urandom_range(0, 255)); while (is_escape_char(c));
          s.push_back(jsu_pkg::ChBackslash);
          s.push_back(c);
        end else begin
          s.push_back(jsu_pkg::ChBackslash);
        end
      end
      // cut short so the string may end inside an escape
      if ($urandom_range(0, 9) == 0 && s.size() > 1) begin
        cut = $urandom_range(1, s.size() - 1);
        while (s.size() > cut) s.delete(s.size() - 1);
      end
    end
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, 1'b0, '0);
    strings_sent++;
  endtask

  // receiver: always ready, coin flips, or occasional long stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 20);
            out_ready  <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
    if ($urandom_range(0, 99) == 0) rx_mode <= $urandom_range(0, 2);
  end

  jsu_pkg::res_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (unesc_q.size() == 0) begin
        $error("unexpected transaction: out_byte %h out_last %b bad_escape %b",
               out_data, out_last, out_bad);
        errors++;
      end else begin
        exp_res = unesc_q.pop_front();
        bytes_out++;
        if (out_data !== exp_res.data) begin
          $error("out_byte: expected %h, got %h", exp_res.data, out_data);
          errors++;
        end
        if (out_last !== exp_res.last) begin
          $error("out_last: expected %b, got %b", exp_res.last, out_last);
          errors++;
        end
        if (out_bad !== exp_res.bad) begin
          $error("bad_escape: expected %b, got %b", exp_res.bad, out_bad);
          errors++;
        end
      end
    end
  end

  initial begin
    int live_target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero byte right after reset, then the top byte closing a string
    add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
    add_row(8'hff, 1'b1, 1'b1, 8'hff, 1'b1, 1'b0);
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChQuote, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChT, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
    // string ends on a backslash
    add_row(jsu_pkg::ChBackslash, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);
    // unknown escape, then the rest of the string is dropped
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("q", 1'b0, 1'b1, 8'h00, 1'b1, 1'b1);
    add_row("z", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("z", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
    // largest one-byte code point
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChU, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("0", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("7", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("f", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    // largest code point, mixed-case digits
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChU, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("F", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("f", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("F", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row("f", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
    // string ends on the u
    add_row(jsu_pkg::ChBackslash, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(jsu_pkg::ChU, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
    end
    hold_until_drained();

    live_target = live_items + RandomBytes;
    while (live_items < live_target) begin
      send_string();
      if ($urandom_range(0, 24) == 0) hold_until_drained();
    end
    hold_until_drained();
    repeat (12) @(posedge clk_i);

    $display("sent %0d bytes in %0d strings, checked %0d output transactions",
             bytes_in, strings_sent, bytes_out);
    $display("covered %0d unicode escapes and %0d malformed or unterminated escapes",
             unicode_seen, malformed_seen);
    if (errors == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

endmodule
